// ===== rtl/core/dlr_pkg.sv =====
`default_nettype none

package dlr_pkg;

    // Dash pattern storage
    localparam int DASH_REGS   = 4;
    localparam int PATTERN_LEN = 4;
    localparam int DASH_IDX_W  = $clog2(DASH_REGS);
    localparam int NEXT_W      = DASH_IDX_W + 1;
    localparam int DASH_W      = 8;
    localparam int DLEFT_W     = DASH_W + 1;

    // First dash index that wraps back to dash 0
    localparam logic [NEXT_W-1:0] DASH_LIMIT =
        (PATTERN_LEN < DASH_REGS) ? NEXT_W'(PATTERN_LEN) : NEXT_W'(DASH_REGS);

    localparam logic [DASH_W-1:0] DASH_RESET [DASH_REGS] = '{8'd4, 8'd4, 8'd0, 8'd0};

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_END   = 3'd5;

    // Item kinds
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Slope ratio minor*256/major, 0..256
    localparam int RATIO_W = 9;
    localparam logic [RATIO_W-1:0] RATIO_FULL = 9'd256;

    // Stretch factor in unsigned 1.16 fixed point, counter in signed 2.16 fixed point
    localparam int STRETCH_W = 17;
    localparam int COUNT_W   = 18;
    localparam logic signed [COUNT_W-1:0] UNIT = 18'sd65536;

    // Three-piece stretch mapping
    localparam logic [RATIO_W-1:0]   BREAK_HI  = 9'd107;
    localparam logic [RATIO_W-1:0]   BREAK_LO  = 9'd45;
    localparam logic [STRETCH_W-1:0] OFS_HI    = 17'd99855;
    localparam logic [STRETCH_W-1:0] SLOPE_HI  = 17'd134;
    localparam logic [STRETCH_W-1:0] OFS_MID   = 17'd95468;
    localparam logic [STRETCH_W-1:0] SLOPE_MID = 17'd93;
    localparam logic [STRETCH_W-1:0] OFS_LO    = 17'd92678;
    localparam logic [STRETCH_W-1:0] SLOPE_LO  = 17'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ORDER,
        S_DIV,
        S_MAP,
        S_STEP
    } t_state;

    // Map a slope ratio to its stretch factor
    function automatic logic [STRETCH_W-1:0] stretch_of(input logic [RATIO_W-1:0] ratio);
        logic [STRETCH_W-1:0] ratio_ext;
        logic [STRETCH_W-1:0] result;
        ratio_ext = STRETCH_W'(ratio);
        if (ratio >= BREAK_HI) begin
            result = OFS_HI - STRETCH_W'(SLOPE_HI * ratio_ext);
        end else if (ratio >= BREAK_LO) begin
            result = OFS_MID - STRETCH_W'(SLOPE_MID * ratio_ext);
        end else begin
            result = OFS_LO - STRETCH_W'(SLOPE_LO * ratio_ext);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dlr_divider.sv =====
`default_nettype none

// Restoring divider for the slope ratio: quotient = num*256/den, num <= den.
// One compare and subtract per cycle, one quotient bit per cycle.
module dlr_divider #(
    parameter int W = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [W-1:0]                 i_num,
    input  wire logic [W-1:0]                 i_den,
    output logic                              o_done,
    output logic [dlr_pkg::RATIO_W-1:0]       o_quot
);
    import dlr_pkg::*;

    localparam int CNT_W = $clog2(RATIO_W + 1);

    logic [W:0]         r_rem;
    logic [W-1:0]       r_den;
    logic [RATIO_W-1:0] r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [W:0] diff;
    logic [W:0] kept;
    logic       ge;

    // Compare and subtract, keep the partial remainder
    always_comb begin
        ge   = r_rem >= {1'b0, r_den};
        diff = r_rem - {1'b0, r_den};
        kept = ge ? diff : r_rem;
    end

    // Sequence the quotient bits, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RATIO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {kept[W-1:0], 1'b0};
            r_quot <= {r_quot[RATIO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/core/dashed_line_rasterizer_core.sv =====
// Begin transaction: after acceptance the item runs through S_SETUP, S_ORDER, S_DIV (the
//   slope divide) and S_MAP, which loads the result; the next item is taken in S_IDLE.
// Step transaction: S_STEP loads the result; no new item is taken until the step is done.
// A result waiting at the output stalls only the final state (S_MAP or S_STEP) of the next item.
// Synchronous active-low reset: dash lengths 4,4,0,0, marks off, no line active
//   (steps return the current pixel with done set), output empty.
`default_nettype none

module dashed_line_rasterizer_core #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dlr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dlr_pkg::DASH_W-1:0]          i_cfg_data,
    // Input item channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_kind,
    input  wire logic signed [COORD_BITS-1:0]        i_start_x,
    input  wire logic signed [COORD_BITS-1:0]        i_start_y,
    input  wire logic signed [COORD_BITS-1:0]        i_end_x,
    input  wire logic signed [COORD_BITS-1:0]        i_end_y,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [COORD_BITS-1:0]             o_pixel_x,
    output logic signed [COORD_BITS-1:0]             o_pixel_y,
    output logic                                     o_plot,
    output logic                                     o_done_res
);
    import dlr_pkg::*;

    localparam int CW = COORD_BITS;

    // Sequencer
    t_state r_state, n_state;
    logic   in_ready;
    logic   div_start;
    logic   emit;
    logic   out_free;
    logic   in_accept;

    // Configuration
    logic [DASH_W-1:0] r_dash_len [DASH_REGS];
    logic              r_mark_start;
    logic              r_mark_end;

    // Latched item
    logic               r_kind;
    logic signed [CW-1:0] r_in_x0, r_in_y0, r_in_x1, r_in_y1;

    // Line state
    logic [CW-1:0]          r_abs_dx, r_abs_dy;
    logic                   r_neg_x, r_neg_y;
    logic                   r_x_major;
    logic [CW-1:0]          r_major;
    logic signed [CW-1:0]   r_cur_x, r_cur_y, r_target;
    logic [CW:0]            r_bres;
    logic [STRETCH_W-1:0]   r_stretch;
    logic signed [COUNT_W-1:0] r_scount;
    logic [DASH_IDX_W-1:0]  r_dash_idx;
    logic signed [DLEFT_W-1:0] r_dash_left;
    logic                   r_pen;
    logic                   r_finished;

    // Output register
    logic                 r_out_valid;
    logic signed [CW-1:0] r_pix_x, r_pix_y;
    logic                 r_plot, r_done;

    // Divider
    logic               div_done;
    logic [RATIO_W-1:0] div_quot;

    // Next values for line state and result
    logic signed [CW-1:0]      n_cur_x, n_cur_y, n_target;
    logic [CW:0]               n_bres;
    logic [STRETCH_W-1:0]      n_stretch;
    logic signed [COUNT_W-1:0] n_scount;
    logic [DASH_IDX_W-1:0]     n_dash_idx;
    logic signed [DLEFT_W-1:0] n_dash_left;
    logic                      n_pen, n_finished, n_plot;

    // Setup and ordering
    logic signed [CW:0] dx_fwd, dx_rev, dy_fwd, dy_rev;
    logic               x_major_now;
    logic [CW-1:0]      major_now, minor_now;

    // Step datapath
    logic signed [CW-1:0]      x_stepped, y_stepped;
    logic [CW-1:0]             step_major, step_minor;
    logic [CW:0]               err_sum;
    logic                      err_take;
    logic signed [COUNT_W-1:0] scount_sub;
    logic                      tick;
    logic signed [DLEFT_W-1:0] dleft_dec;
    logic                      dash_end;
    logic [NEXT_W-1:0]         next_idx;
    logic [DASH_W-1:0]         next_len;
    logic                      wrap;
    logic                      reached;
    logic [RATIO_W-1:0]        ratio;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_accept) n_state = (i_kind == KIND_BEGIN) ? S_SETUP : S_STEP;
            S_SETUP: n_state = S_ORDER;
            S_ORDER: n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_MAP;
            S_MAP:   if (out_free) n_state = S_IDLE;
            S_STEP:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        case (r_state)
            S_IDLE:  in_ready  = 1'b1;
            S_ORDER: div_start = 1'b1;
            S_MAP:   emit      = out_free;
            S_STEP:  emit      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = in_ready;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DASH_REGS; i++) begin
                r_dash_len[i] <= DASH_RESET[i];
            end
            r_mark_start <= 1'b0;
            r_mark_end   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DASH_0, REG_DASH_1, REG_DASH_2, REG_DASH_3: begin
                    r_dash_len[i_cfg_index[DASH_IDX_W-1:0]] <= i_cfg_data;
                end
                REG_MARK_START: r_mark_start <= i_cfg_data[0];
                REG_MARK_END:   r_mark_end   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_kind;
            r_in_x0 <= i_start_x;
            r_in_y0 <= i_start_y;
            r_in_x1 <= i_end_x;
            r_in_y1 <= i_end_y;
        end
    end

    // Deltas in both directions, pick the magnitude by sign
    always_comb begin
        dx_fwd = (CW+1)'(r_in_x1) - (CW+1)'(r_in_x0);
        dx_rev = (CW+1)'(r_in_x0) - (CW+1)'(r_in_x1);
        dy_fwd = (CW+1)'(r_in_y1) - (CW+1)'(r_in_y0);
        dy_rev = (CW+1)'(r_in_y0) - (CW+1)'(r_in_y1);
    end

    // Choose the major axis
    always_comb begin
        x_major_now = r_abs_dx >= r_abs_dy;
        major_now   = x_major_now ? r_abs_dx : r_abs_dy;
        minor_now   = x_major_now ? r_abs_dy : r_abs_dx;
    end

    dlr_divider #(
        .W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (minor_now),
        .i_den   (major_now),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Advance one pixel along the line
    always_comb begin
        x_stepped  = r_neg_x ? r_cur_x - CW'(1) : r_cur_x + CW'(1);
        y_stepped  = r_neg_y ? r_cur_y - CW'(1) : r_cur_y + CW'(1);
        step_major = r_x_major ? r_abs_dx : r_abs_dy;
        step_minor = r_x_major ? r_abs_dy : r_abs_dx;
        err_sum    = r_bres + {1'b0, step_minor};
        err_take   = err_sum >= {1'b0, step_major};

        scount_sub = r_scount - UNIT;
        tick       = scount_sub[COUNT_W-1] || (scount_sub == '0);
        dleft_dec  = r_dash_left - DLEFT_W'(1);
        dash_end   = tick && (dleft_dec[DLEFT_W-1] || (dleft_dec == '0));
        next_idx   = {1'b0, r_dash_idx} + NEXT_W'(1);
        next_len   = r_dash_len[next_idx[DASH_IDX_W-1:0]];
        wrap       = (next_idx >= DASH_LIMIT) || (next_len == '0);

        ratio      = (r_major == '0) ? RATIO_FULL : div_quot;
    end

    // Next line state and result for begin and step
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_target    = r_target;
        n_bres      = r_bres;
        n_stretch   = r_stretch;
        n_scount    = r_scount;
        n_dash_idx  = r_dash_idx;
        n_dash_left = r_dash_left;
        n_pen       = r_pen;
        n_finished  = r_finished;
        n_plot      = 1'b0;
        reached     = 1'b0;
        if (r_kind == KIND_BEGIN) begin
            n_cur_x     = r_in_x0;
            n_cur_y     = r_in_y0;
            n_target    = r_x_major ? r_in_x1 : r_in_y1;
            n_bres      = {2'b00, r_major[CW-1:1]};
            n_stretch   = stretch_of(ratio);
            n_scount    = $signed({1'b0, stretch_of(ratio)});
            n_dash_idx  = '0;
            n_dash_left = $signed({1'b0, r_dash_len[0]});
            n_pen       = 1'b1;
            n_finished  = (r_major == '0);
            n_plot      = r_mark_start || ((r_major == '0) && r_mark_end);
        end else if (!r_finished) begin
            // Bresenham step
            if (r_x_major) begin
                n_cur_x = x_stepped;
                if (err_take) n_cur_y = y_stepped;
            end else begin
                n_cur_y = y_stepped;
                if (err_take) n_cur_x = x_stepped;
            end
            n_bres = err_take ? err_sum - {1'b0, step_major} : err_sum;

            // Stretch counter and dash walk
            n_scount = tick ? scount_sub + $signed({1'b0, r_stretch}) : scount_sub;
            if (dash_end) begin
                if (wrap) begin
                    n_dash_idx  = '0;
                    n_dash_left = $signed({1'b0, r_dash_len[0]});
                    n_pen       = 1'b1;
                end else begin
                    n_dash_idx  = next_idx[DASH_IDX_W-1:0];
                    n_dash_left = $signed({1'b0, next_len});
                    n_pen       = !r_pen;
                end
            end else if (tick) begin
                n_dash_left = dleft_dec;
            end

            reached    = (r_x_major ? n_cur_x : n_cur_y) == r_target;
            n_finished = reached;
            n_plot     = r_pen || (reached && r_mark_end);
        end
    end

    // Line state: geometry in S_SETUP and S_ORDER, the rest when the result goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_dx    <= '0;
            r_abs_dy    <= '0;
            r_neg_x     <= 1'b0;
            r_neg_y     <= 1'b0;
            r_x_major   <= 1'b1;
            r_major     <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_target    <= '0;
            r_bres      <= '0;
            r_stretch   <= '0;
            r_scount    <= '0;
            r_dash_idx  <= '0;
            r_dash_left <= '0;
            r_pen       <= 1'b1;
            r_finished  <= 1'b1;
        end else begin
            if (r_state == S_SETUP) begin
                r_neg_x  <= dx_fwd[CW];
                r_neg_y  <= dy_fwd[CW];
                r_abs_dx <= dx_fwd[CW] ? dx_rev[CW-1:0] : dx_fwd[CW-1:0];
                r_abs_dy <= dy_fwd[CW] ? dy_rev[CW-1:0] : dy_fwd[CW-1:0];
            end
            if (r_state == S_ORDER) begin
                r_x_major <= x_major_now;
                r_major   <= major_now;
            end
            if (emit) begin
                r_cur_x     <= n_cur_x;
                r_cur_y     <= n_cur_y;
                r_target    <= n_target;
                r_bres      <= n_bres;
                r_stretch   <= n_stretch;
                r_scount    <= n_scount;
                r_dash_idx  <= n_dash_idx;
                r_dash_left <= n_dash_left;
                r_pen       <= n_pen;
                r_finished  <= n_finished;
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pix_x <= n_cur_x;
            r_pix_y <= n_cur_y;
            r_plot  <= n_plot;
            r_done  <= n_finished;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_pix_x;
    assign o_pixel_y   = r_pix_y;
    assign o_plot      = r_plot;
    assign o_done_res  = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/dlr_checker.sv =====
`default_nettype none

module dlr_checker #(
    parameter int COORD_BITS = 16
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         i_kind,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic signed [COORD_BITS-1:0] o_pixel_x,
    input wire logic signed [COORD_BITS-1:0] o_pixel_y,
    input wire logic                         o_plot,
    input wire logic                         o_done_res
);
    import dlr_pkg::*;

    // A result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_plot) && $stable(o_done_res)))
        else $error("stalled result changed");

    // One transaction at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    // A begin transaction still holds the input closed when it reaches S_ORDER
    a_begin_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == KIND_BEGIN) |=> ##1 !o_in_ready)
        else $error("begin transaction finished too early");

    // A new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without an item in progress");

endmodule

bind dashed_line_rasterizer_core dlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_dlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pixel_x   (o_pixel_x),
    .o_pixel_y   (o_pixel_y),
    .o_plot      (o_plot),
    .o_done_res  (o_done_res)
);

`default_nettype wire

// ===== test/dashed_line_rasterizer_core_tb.sv =====
`timescale 1ns / 100ps

module dashed_line_rasterizer_core_tb;
    import dlr_pkg::*;

    localparam int COORD_W       = 16;
    localparam int STEP_UNIT     = 65536;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 25;
    localparam int LONG_SPAN     = 300;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 5_000_000;

    // Indexes past the last register; writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      plot;
        logic                      done;
    } t_pixel;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_op;

    // Register rows carry the index in sx and the value in sy
    typedef struct packed {
        t_row_op                   op;
        logic                      kind;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      typed;
        t_pixel                    want;
    } t_stim_row;

    localparam t_stim_row STEP_ROW = '{ROW_ITEM, KIND_STEP, '0, '0, '0, '0, 1'b0, '0};

    localparam int DIRECTED_ROWS = 30;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // step with no line active repeats the reset pixel, done set
        '{ROW_ITEM, KIND_STEP, '0, '0, '0, '0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
        // zero-length line at the coordinate extremes, then a step past its end
        '{ROW_ITEM, KIND_BEGIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1,
          '{COORD_MAX, COORD_MIN, 1'b0, 1'b1}},
        '{ROW_ITEM, KIND_STEP, '0, '0, '0, '0, 1'b1, '{COORD_MAX, COORD_MIN, 1'b0, 1'b1}},
        // full-range diagonal, walked two pixels
        '{ROW_ITEM, KIND_BEGIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1,
          '{COORD_MIN, COORD_MAX, 1'b0, 1'b0}},
        STEP_ROW, STEP_ROW,
        // both marks on, plus a write to a spare index
        '{ROW_REG, KIND_STEP, COORD_W'(REG_MARK_START), 16'sd1, '0, '0, 1'b0, '0},
        '{ROW_REG, KIND_STEP, COORD_W'(REG_MARK_END), 16'sd1, '0, '0, 1'b0, '0},
        '{ROW_REG, KIND_STEP, COORD_W'(REG_SPARE_HI), 16'sd255, '0, '0, 1'b0, '0},
        '{ROW_ITEM, KIND_BEGIN, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1,
          '{16'sd5, 16'sd5, 1'b1, 1'b1}},
        // steep line toward negative y, stepped one past its end
        '{ROW_ITEM, KIND_BEGIN, 16'sd0, 16'sd0, 16'sd3, -16'sd7, 1'b1,
          '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW,
        // empty first dash, start mark off again
        '{ROW_REG, KIND_STEP, COORD_W'(REG_DASH_0), 16'sd0, '0, '0, 1'b0, '0},
        '{ROW_REG, KIND_STEP, COORD_W'(REG_DASH_1), 16'sd1, '0, '0, 1'b0, '0},
        '{ROW_REG, KIND_STEP, COORD_W'(REG_MARK_START), 16'sd0, '0, '0, 1'b0, '0},
        '{ROW_ITEM, KIND_BEGIN, -16'sd4, 16'sd2, -16'sd10, 16'sd4, 1'b1,
          '{-16'sd4, 16'sd2, 1'b0, 1'b0}},
        STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW, STEP_ROW
    };

    // Register settings per phase; rows flagged in RANDOM_REGS are drawn at run time
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
        REG_DASH_0, REG_DASH_1, REG_DASH_2, REG_DASH_3, REG_MARK_START, REG_MARK_END
    };
    localparam logic [DASH_W-1:0] PHASE_REGS [PHASES][6] = '{
        '{8'd4,   8'd4,   8'd0,   8'd0,   8'd0, 8'd0},
        '{8'd1,   8'd1,   8'd1,   8'd1,   8'd1, 8'd0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd1},
        '{8'd3,   8'd0,   8'd7,   8'd9,   8'd0, 8'd1},
        '{8'd2,   8'd5,   8'd1,   8'd0,   8'd1, 8'd1},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 8'd0},
        '{8'd1,   8'd255, 8'd0,   8'd0,   8'd0, 8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 8'd0}
    };
    localparam logic [PHASES-1:0] RANDOM_REGS = 9'b110100000;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [DASH_W-1:0]         i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic                      i_kind      = KIND_BEGIN;
    logic signed [COORD_W-1:0] i_start_x   = '0;
    logic signed [COORD_W-1:0] i_start_y   = '0;
    logic signed [COORD_W-1:0] i_end_x     = '0;
    logic signed [COORD_W-1:0] i_end_y     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [COORD_W-1:0] o_pixel_x;
    logic signed [COORD_W-1:0] o_pixel_y;
    logic                      o_plot;
    logic                      o_done_res;

    // Hard-coded expectation that travels with the current transaction
    logic   item_typed     = 1'b0;
    t_pixel item_typed_res = '0;

    t_pixel pending_pixels[$];
    int     pixel_errors  = 0;
    int     items_sent    = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_requests = 0;
    int     holds_served  = 0;
    int     hold_left     = 0;

    // Predictor copy of the registers and the line walker
    logic [DASH_W-1:0] dash_cfg [DASH_REGS];
    logic              mark_start_cfg;
    logic              mark_end_cfg;
    int                pos_x, pos_y, goal_major;
    int                span_x, span_y, err_acc;
    int                stretch_fx, stretch_acc, dash_sel, dash_left;
    bit                neg_x, neg_y, walk_x, pen, line_done;

    dashed_line_rasterizer_core #(
        .COORD_BITS (COORD_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_plot      (o_plot),
        .o_done_res  (o_done_res)
    );

    always #5 i_clk = ~i_clk;

    // Walk the line one pixel per step and work out the pixel the block reports
    task automatic trace_pixel(input logic kind,
                               input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                               output t_pixel res);
        int   x0, y0, x1, y1, dx, dy, major, minor, ratio;
        logic plot_now;
        if (kind == KIND_BEGIN) begin
            x0 = sx;
            y0 = sy;
            x1 = ex;
            y1 = ey;
            dx = x1 - x0;
            dy = y1 - y0;
            neg_x = (dx < 0);
            neg_y = (dy < 0);
            span_x = neg_x ? -dx : dx;
            span_y = neg_y ? -dy : dy;
            walk_x = (span_x >= span_y);
            major = walk_x ? span_x : span_y;
            minor = walk_x ? span_y : span_x;
            ratio = (major != 0) ? (minor * 256) / major : 256;
            // three-piece slope stretch in 16.16
            if (ratio >= 107) begin
                stretch_fx = 99855 - 134 * ratio;
            end else if (ratio >= 45) begin
                stretch_fx = 95468 - 93 * ratio;
            end else begin
                stretch_fx = 92678 - 31 * ratio;
            end
            stretch_acc = stretch_fx;
            dash_sel = 0;
            dash_left = int'(dash_cfg[0]);
            pen = 1'b1;
            pos_x = x0;
            pos_y = y0;
            goal_major = walk_x ? x1 : y1;
            err_acc = major >> 1;
            line_done = (major == 0);
            plot_now = mark_start_cfg || (line_done && mark_end_cfg);
        end else if (line_done) begin
            plot_now = 1'b0;
        end else begin
            // advance the major axis, carry into the minor one
            if (walk_x) begin
                pos_x += neg_x ? -1 : 1;
                err_acc += span_y;
                if (err_acc >= span_x) begin
                    pos_y += neg_y ? -1 : 1;
                    err_acc -= span_x;
                end
            end else begin
                pos_y += neg_y ? -1 : 1;
                err_acc += span_x;
                if (err_acc >= span_y) begin
                    pos_x += neg_x ? -1 : 1;
                    err_acc -= span_y;
                end
            end
            plot_now = pen;
            // spend one dash unit each time the stretch counter runs out
            stretch_acc -= STEP_UNIT;
            if (stretch_acc <= 0) begin
                stretch_acc += stretch_fx;
                dash_left -= 1;
                if (dash_left <= 0) begin
                    pen = !pen;
                    if (dash_sel + 1 >= PATTERN_LEN || dash_sel + 1 >= DASH_REGS ||
                        dash_cfg[dash_sel + 1] == '0) begin
                        dash_sel = 0;
                        dash_left = int'(dash_cfg[0]);
                        pen = 1'b1;
                    end else begin
                        dash_sel += 1;
                        dash_left = int'(dash_cfg[dash_sel]);
                    end
                end
            end
            if ((walk_x ? pos_x : pos_y) == goal_major) begin
                line_done = 1'b1;
                if (mark_end_cfg) begin
                    plot_now = 1'b1;
                end
            end
        end
        res.x    = pos_x[COORD_W-1:0];
        res.y    = pos_y[COORD_W-1:0];
        res.plot = plot_now;
        res.done = line_done;
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    // Present one item, with random gaps ahead of it, and hold it until taken
    task automatic offer_item(input logic kind,
                              input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                              input logic typed, input t_pixel typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_start_x      <= sx;
        i_start_y      <= sy;
        i_end_x        <= ex;
        i_end_y        <= ey;
        item_typed     <= typed;
        item_typed_res <= typed_res;
        items_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Leaves i_cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DASH_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stop offering and wait until every pixel has come back
    task automatic quiesce();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Begin a line of the given major span from a random start, then step along it
    task automatic send_line(input int span, input int minor_len);
        int x0, y0, x1, y1, dx, dy, steps;
        bit along_x;
        along_x = 1'($urandom_range(1));
        dx = along_x ? span : minor_len;
        dy = along_x ? minor_len : span;
        if ($urandom_range(1) == 1) dx = -dx;
        if ($urandom_range(1) == 1) dy = -dy;
        x0 = rand_coord();
        y0 = rand_coord();
        x1 = x0 + dx;
        y1 = y0 + dy;
        if (x1 > int'(COORD_MAX) || x1 < int'(COORD_MIN)) x1 = x0 - dx;
        if (y1 > int'(COORD_MAX) || y1 < int'(COORD_MIN)) y1 = y0 - dy;
        offer_item(KIND_BEGIN, COORD_W'(x0), COORD_W'(y0), COORD_W'(x1), COORD_W'(y1),
                   1'b0, '0);
        // mostly run to the end and a little past it; sometimes abandon early
        steps = ($urandom_range(9) == 0) ? int'($urandom_range(span))
                                         : span + int'($urandom_range(2));
        repeat (steps) begin
            offer_item(KIND_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       1'b0, '0);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check results, track register writes, predict each accepted transaction
    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel calc;
        if (!i_rst_n) begin
            dash_cfg[0]    = 8'd4;
            dash_cfg[1]    = 8'd4;
            dash_cfg[2]    = 8'd0;
            dash_cfg[3]    = 8'd0;
            mark_start_cfg = 1'b0;
            mark_end_cfg   = 1'b0;
            pos_x = 0;
            pos_y = 0;
            goal_major = 0;
            span_x = 0;
            span_y = 0;
            neg_x = 1'b0;
            neg_y = 1'b0;
            walk_x = 1'b1;
            err_acc = 0;
            stretch_fx = 0;
            stretch_acc = 0;
            dash_sel = 0;
            dash_left = 0;
            pen = 1'b1;
            line_done = 1'b1;
            pending_pixels.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    pixel_errors++;
                    if (pixel_errors <= REPORT_LIMIT) begin
                        $display("%0t: unexpected pixel x=%0d y=%0d plot=%0b done=%0b", $time,
                                 o_pixel_x, o_pixel_y, o_plot, o_done_res);
                    end
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_pixel_x !== want.x || o_pixel_y !== want.y ||
                        o_plot !== want.plot || o_done_res !== want.done) begin
                        pixel_errors++;
                        if (pixel_errors <= REPORT_LIMIT) begin
                            $display("%0t: pixel mismatch: got x=%0d y=%0d plot=%0b done=%0b,",
                                     $time, o_pixel_x, o_pixel_y, o_plot, o_done_res);
                            $display("    expected x=%0d y=%0d plot=%0b done=%0b",
                                     want.x, want.y, want.plot, want.done);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DASH_0, REG_DASH_1, REG_DASH_2, REG_DASH_3: begin
                        dash_cfg[i_cfg_index[DASH_IDX_W-1:0]] = i_cfg_data;
                    end
                    REG_MARK_START: begin
                        mark_start_cfg = i_cfg_data[0];
                    end
                    REG_MARK_END: begin
                        mark_end_cfg = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                trace_pixel(i_kind, i_start_x, i_start_y, i_end_x, i_end_y, calc);
                pending_pixels.push_back(item_typed ? item_typed_res : calc);
            end
        end
    end

    // Stimulus: directed table, then phases of random lines under varying registers
    initial begin
        int r;
        int p;
        int k;
        int roll;
        int span;
        int phase_goal;
        logic [DASH_W-1:0] val;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 54;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].op == ROW_REG) begin
                quiesce();
                write_reg(DIRECTED[r].sx[CFG_IDX_W-1:0], DIRECTED[r].sy[DASH_W-1:0]);
            end else begin
                i_cfg_valid <= 1'b0;
                offer_item(DIRECTED[r].kind, DIRECTED[r].sx, DIRECTED[r].sy,
                           DIRECTED[r].ex, DIRECTED[r].ey,
                           DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            // reprogram with the block idle
            quiesce();
            for (k = 0; k < 6; k++) begin
                if (RANDOM_REGS[p]) begin
                    if (k < 4) begin
                        val = ($urandom_range(3) == 0) ? '0 : DASH_W'($urandom_range(12, 1));
                    end else begin
                        val = DASH_W'($urandom_range(1));
                    end
                end else begin
                    val = PHASE_REGS[p][k];
                end
                // toggle the unused upper bits of the mark registers
                if (k >= 4) val = {7'($urandom), val[0]};
                write_reg(REG_ORDER[k], val);
            end
            write_reg((p % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, DASH_W'($urandom));
            i_cfg_valid <= 1'b0;

            // back up the output while lines keep coming
            if (p == 1 || p == 7) hold_requests++;
            // long diagonal so the first 255-long dash runs out
            if (p == 2) send_line(LONG_SPAN, LONG_SPAN);

            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                roll = $urandom_range(99);
                if (roll < 5) begin
                    quiesce();
                end else if (roll < 15) begin
                    repeat ($urandom_range(4, 1)) begin
                        offer_item(1'($urandom_range(1)), rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord(), 1'b0, '0);
                    end
                end else begin
                    span = ($urandom_range(15) == 0) ? int'($urandom_range(120, 41))
                                                     : int'($urandom_range(40));
                    send_line(span, $urandom_range(span));
                end
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pixel_errors == 0 && pending_pixels.size() == 0) begin
            $display("dashed_line_rasterizer_core_tb: clean");
        end else begin
            $display("dashed_line_rasterizer_core_tb: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("dashed_line_rasterizer_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dlr_pkg.sv
rtl/core/dlr_divider.sv
rtl/core/dashed_line_rasterizer_core.sv
rtl/core/dlr_checker.sv
test/dashed_line_rasterizer_core_tb.sv
